>>> sv/imhq_pkg.sv
// shared types and constants for the indexed min-heap queue
// no dependencies
`default_nettype none
package imhq_pkg;

  localparam int MAX_VERTICES = 1024;
  localparam int SLOT_W       = $clog2(MAX_VERTICES);
  localparam int CNT_W        = $clog2(MAX_VERTICES + 1);
  localparam int V_W          = 10;
  localparam int D_W          = 31;
  localparam int HEAP_W       = V_W + D_W;

  typedef enum logic [1:0] {
    REQ_LOAD    = 2'd0,
    REQ_EXTRACT = 2'd1,
    REQ_DECR    = 2'd2,
    REQ_QUERY   = 2'd3
  } req_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_EMPTY  = 2'd1,
    ST_FULL   = 2'd2,
    ST_ABSENT = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_PR_POS,
    S_PR_HEAP,
    S_PR_CHK,
    S_UP,
    S_UP_CMP,
    S_EXT_ROOT,
    S_EXT_LAST,
    S_EXT_POS,
    S_DN,
    S_DN_L,
    S_DN_R,
    S_DN_MV,
    S_RESP
  } state_t;

endpackage
`default_nettype wire

>>> sv/indexed_min_heap_queue.sv
// indexed min-heap priority queue top level: sequencer, heap and position rams
// depends on imhq_pkg and imhq_ram
`default_nettype none
// One request at a time. After reset all MAX_VERTICES (1024) entries of the
// position table are swept before the first request is taken. A query or a
// rejected load/decrease only looks up the vertex; a load or decrease-key then
// climbs the heap level by level and an extract descends it level by level,
// with the heap ram reads done one at a time through its single read port. A
// finished result waits in the output register while the next request is
// taken.
module indexed_min_heap_queue (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic [1:0]                  in_req_type,
  input  wire logic [imhq_pkg::V_W-1:0]    in_vertex,
  input  wire logic [imhq_pkg::D_W-1:0]    in_distance,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic      [imhq_pkg::V_W-1:0]    out_vertex,
  output logic      [imhq_pkg::D_W-1:0]    out_distance,
  output logic                             out_in_queue,
  output logic      [1:0]                  out_status,
  output logic      [imhq_pkg::CNT_W-1:0]  out_count
);

  localparam int SW = imhq_pkg::SLOT_W;
  localparam int CW = imhq_pkg::CNT_W;
  localparam int VW = imhq_pkg::V_W;
  localparam int DW = imhq_pkg::D_W;
  localparam int HW = imhq_pkg::HEAP_W;

  imhq_pkg::state_t state_r, state_nxt;

  logic [SW-1:0] clr_r, clr_nxt;
  logic [1:0]    req_r, req_nxt;
  logic [VW-1:0] v_r, v_nxt;
  logic [DW-1:0] d_r, d_nxt;
  logic [CW-1:0] p_r, p_nxt;
  logic [CW-1:0] size_r, size_nxt;
  logic [SW-1:0] idx_r, idx_nxt;
  logic [VW-1:0] cv_r, cv_nxt;
  logic [DW-1:0] cd_r, cd_nxt;
  logic [SW-1:0] best_r, best_nxt;
  logic [VW-1:0] bv_r, bv_nxt;
  logic [DW-1:0] bd_r, bd_nxt;
  logic [VW-1:0] res_v_r, res_v_nxt;
  logic [DW-1:0] res_d_r, res_d_nxt;
  logic          res_in_r, res_in_nxt;
  logic [1:0]    res_st_r, res_st_nxt;

  logic          out_valid_r;
  logic [VW-1:0] out_vertex_r;
  logic [DW-1:0] out_distance_r;
  logic          out_in_r;
  logic [1:0]    out_status_r;
  logic [CW-1:0] out_count_r;

  logic          heap_we;
  logic [SW-1:0] heap_waddr, heap_raddr;
  logic [HW-1:0] heap_wdata, heap_rdata;
  logic          pos_we;
  logic [SW-1:0] pos_waddr, pos_raddr;
  logic [CW-1:0] pos_wdata, pos_rdata;

  logic [VW-1:0] hv;
  logic [DW-1:0] hd;
  logic          accept, present, full, resp_load, go_up;
  logic [SW-1:0] parent;
  logic [CW-1:0] left;
  logic [CW:0]   right;
  logic          left_ok, right_ok;

  imhq_ram #(.WIDTH(HW), .DEPTH(imhq_pkg::MAX_VERTICES)) u_heap_ram (
    .clk   (clk),
    .we    (heap_we),
    .waddr (heap_waddr),
    .wdata (heap_wdata),
    .raddr (heap_raddr),
    .rdata (heap_rdata)
  );

  imhq_ram #(.WIDTH(CW), .DEPTH(imhq_pkg::MAX_VERTICES)) u_pos_ram (
    .clk   (clk),
    .we    (pos_we),
    .waddr (pos_waddr),
    .wdata (pos_wdata),
    .raddr (pos_raddr),
    .rdata (pos_rdata)
  );

  assign hv        = heap_rdata[HW-1:DW];
  assign hd        = heap_rdata[DW-1:0];
  assign accept    = (state_r == imhq_pkg::S_IDLE) && in_valid;
  assign present   = (p_r < size_r) && (hv == v_r);
  assign full      = (size_r == CW'(imhq_pkg::MAX_VERTICES));
  assign parent    = (idx_r - SW'(1)) >> 1;
  assign left      = CW'({idx_r, 1'b1});
  assign right     = CW'(left) + (CW + 1)'(1);
  assign left_ok   = ({{(CW - SW){1'b0}}, idx_r} << 1) + CW'(1) < size_r;
  assign right_ok  = right < {1'b0, size_r};
  assign resp_load = (state_r == imhq_pkg::S_RESP) && (!out_valid_r || !out_stall);
  assign go_up     = ((req_r == imhq_pkg::REQ_LOAD) && !present && !full) ||
                     ((req_r == imhq_pkg::REQ_DECR) && present);

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      imhq_pkg::S_CLEAR: begin
        if (clr_r == SW'(imhq_pkg::MAX_VERTICES - 1)) state_nxt = imhq_pkg::S_IDLE;
      end
      imhq_pkg::S_IDLE: begin
        if (accept) begin
          if (in_req_type == imhq_pkg::REQ_EXTRACT) begin
            state_nxt = (size_r == '0) ? imhq_pkg::S_RESP : imhq_pkg::S_EXT_ROOT;
          end else begin
            state_nxt = imhq_pkg::S_PR_POS;
          end
        end
      end
      imhq_pkg::S_PR_POS:   state_nxt = imhq_pkg::S_PR_HEAP;
      imhq_pkg::S_PR_HEAP:  state_nxt = imhq_pkg::S_PR_CHK;
      imhq_pkg::S_PR_CHK:   state_nxt = go_up ? imhq_pkg::S_UP : imhq_pkg::S_RESP;
      imhq_pkg::S_UP:       state_nxt = (idx_r == '0) ? imhq_pkg::S_RESP : imhq_pkg::S_UP_CMP;
      imhq_pkg::S_UP_CMP:   state_nxt = (cd_r < hd) ? imhq_pkg::S_UP : imhq_pkg::S_RESP;
      imhq_pkg::S_EXT_ROOT: state_nxt = imhq_pkg::S_EXT_LAST;
      imhq_pkg::S_EXT_LAST: state_nxt = imhq_pkg::S_EXT_POS;
      imhq_pkg::S_EXT_POS:  state_nxt = imhq_pkg::S_DN;
      imhq_pkg::S_DN:       state_nxt = left_ok ? imhq_pkg::S_DN_L : imhq_pkg::S_RESP;
      imhq_pkg::S_DN_L:     state_nxt = right_ok ? imhq_pkg::S_DN_R : imhq_pkg::S_DN_MV;
      imhq_pkg::S_DN_R:     state_nxt = imhq_pkg::S_DN_MV;
      imhq_pkg::S_DN_MV:    state_nxt = (best_r == idx_r) ? imhq_pkg::S_RESP : imhq_pkg::S_DN;
      imhq_pkg::S_RESP:     state_nxt = resp_load ? imhq_pkg::S_IDLE : imhq_pkg::S_RESP;
      default:              state_nxt = imhq_pkg::S_IDLE;
    endcase
  end

  // datapath and ram control
  always_comb begin
    clr_nxt    = clr_r;
    req_nxt    = req_r;
    v_nxt      = v_r;
    d_nxt      = d_r;
    p_nxt      = p_r;
    size_nxt   = size_r;
    idx_nxt    = idx_r;
    cv_nxt     = cv_r;
    cd_nxt     = cd_r;
    best_nxt   = best_r;
    bv_nxt     = bv_r;
    bd_nxt     = bd_r;
    res_v_nxt  = res_v_r;
    res_d_nxt  = res_d_r;
    res_in_nxt = res_in_r;
    res_st_nxt = res_st_r;
    heap_we    = 1'b0;
    heap_waddr = idx_r;
    heap_wdata = {cv_r, cd_r};
    heap_raddr = '0;
    pos_we     = 1'b0;
    pos_waddr  = cv_r[SW-1:0];
    pos_wdata  = CW'(idx_r);
    pos_raddr  = v_r[SW-1:0];
    unique case (state_r)
      imhq_pkg::S_CLEAR: begin
        pos_we    = 1'b1;
        pos_waddr = clr_r;
        pos_wdata = '1;
        clr_nxt   = clr_r + SW'(1);
      end
      imhq_pkg::S_IDLE: begin
        if (accept) begin
          req_nxt    = in_req_type;
          v_nxt      = in_vertex;
          d_nxt      = in_distance;
          res_v_nxt  = in_vertex;
          res_d_nxt  = '0;
          res_in_nxt = 1'b0;
          res_st_nxt = imhq_pkg::ST_OK;
          if ((in_req_type == imhq_pkg::REQ_EXTRACT) && (size_r == '0)) begin
            res_st_nxt = imhq_pkg::ST_EMPTY;
          end
        end
      end
      imhq_pkg::S_PR_POS: begin
        pos_raddr = v_r[SW-1:0];
      end
      imhq_pkg::S_PR_HEAP: begin
        p_nxt      = pos_rdata;
        heap_raddr = pos_rdata[SW-1:0];
      end
      imhq_pkg::S_PR_CHK: begin
        cv_nxt = v_r;
        cd_nxt = d_r;
        unique case (req_r)
          imhq_pkg::REQ_LOAD: begin
            res_in_nxt = 1'b1;
            if (!present) begin
              if (full) begin
                res_in_nxt = 1'b0;
                res_st_nxt = imhq_pkg::ST_FULL;
              end else begin
                idx_nxt  = size_r[SW-1:0];
                size_nxt = size_r + CW'(1);
              end
            end
          end
          imhq_pkg::REQ_DECR: begin
            if (present) begin
              res_in_nxt = 1'b1;
              idx_nxt    = p_r[SW-1:0];
            end else begin
              res_st_nxt = imhq_pkg::ST_ABSENT;
            end
          end
          imhq_pkg::REQ_QUERY:   res_in_nxt = present;
          imhq_pkg::REQ_EXTRACT: res_in_nxt = 1'b0;
          default:               res_in_nxt = 1'b0;
        endcase
      end
      imhq_pkg::S_UP: begin
        if (idx_r == '0) begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end else begin
          heap_raddr = parent;
        end
      end
      imhq_pkg::S_UP_CMP: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (cd_r < hd) begin
          heap_wdata = heap_rdata;
          pos_waddr  = hv[SW-1:0];
          idx_nxt    = parent;
        end
      end
      imhq_pkg::S_EXT_ROOT: begin
        heap_raddr = '0;
      end
      imhq_pkg::S_EXT_LAST: begin
        res_v_nxt  = hv;
        res_d_nxt  = hd;
        heap_raddr = SW'(size_r - CW'(1));
      end
      imhq_pkg::S_EXT_POS: begin
        cv_nxt    = hv;
        cd_nxt    = hd;
        pos_we    = 1'b1;
        pos_waddr = res_v_r[SW-1:0];
        pos_wdata = size_r - CW'(1);
        size_nxt  = size_r - CW'(1);
        idx_nxt   = '0;
      end
      imhq_pkg::S_DN: begin
        if (left_ok) begin
          heap_raddr = left[SW-1:0];
        end else begin
          heap_we = 1'b1;
          pos_we  = 1'b1;
        end
      end
      imhq_pkg::S_DN_L: begin
        if (hd < cd_r) begin
          best_nxt = left[SW-1:0];
          bv_nxt   = hv;
          bd_nxt   = hd;
        end else begin
          best_nxt = idx_r;
          bv_nxt   = cv_r;
          bd_nxt   = cd_r;
        end
        heap_raddr = right[SW-1:0];
      end
      imhq_pkg::S_DN_R: begin
        if (hd < bd_r) begin
          best_nxt = right[SW-1:0];
          bv_nxt   = hv;
          bd_nxt   = hd;
        end
      end
      imhq_pkg::S_DN_MV: begin
        heap_we = 1'b1;
        pos_we  = 1'b1;
        if (best_r != idx_r) begin
          heap_wdata = {bv_r, bd_r};
          pos_waddr  = bv_r[SW-1:0];
          idx_nxt    = best_r;
        end
      end
      imhq_pkg::S_RESP: begin
        heap_raddr = '0;
      end
      default: begin
        heap_raddr = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= imhq_pkg::S_CLEAR;
      clr_r       <= '0;
      size_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      clr_r    <= clr_nxt;
      size_r   <= size_nxt;
      if (resp_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    req_r    <= req_nxt;
    v_r      <= v_nxt;
    d_r      <= d_nxt;
    p_r      <= p_nxt;
    idx_r    <= idx_nxt;
    cv_r     <= cv_nxt;
    cd_r     <= cd_nxt;
    best_r   <= best_nxt;
    bv_r     <= bv_nxt;
    bd_r     <= bd_nxt;
    res_v_r  <= res_v_nxt;
    res_d_r  <= res_d_nxt;
    res_in_r <= res_in_nxt;
    res_st_r <= res_st_nxt;
    if (resp_load) begin
      out_vertex_r   <= res_v_r;
      out_distance_r <= res_d_r;
      out_in_r       <= res_in_r;
      out_status_r   <= res_st_r;
      out_count_r    <= size_r;
    end
  end

  assign in_stall     = (state_r != imhq_pkg::S_IDLE);
  assign out_valid    = out_valid_r;
  assign out_vertex   = out_vertex_r;
  assign out_distance = out_distance_r;
  assign out_in_queue = out_in_r;
  assign out_status   = out_status_r;
  assign out_count    = out_count_r;

endmodule
`default_nettype wire

>>> sv/imhq_ram.sv
// generic single write, single read ram with registered read data
// no dependencies
`default_nettype none
module imhq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire
